// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define BRB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BRB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/brb_pkg.sv =====
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the byte ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

	localparam int CAPACITY_DEF = 4096;
	localparam int ACT_W        = 4;
	localparam int DATA_W       = 8;
	localparam int LEN_W        = 12;
	localparam int CNT_W        = 12;
	localparam int CONTIG_W     = 13;

	typedef enum logic [ACT_W-1:0] {
		ACT_BEGIN_WRITE   = 4'd0,
		ACT_WRITE_BYTE    = 4'd1,
		ACT_BEGIN_READ    = 4'd2,
		ACT_READ_BYTE     = 4'd3,
		ACT_SKIP          = 4'd4,
		ACT_ADVANCE_WRITE = 4'd5,
		ACT_ADVANCE_READ  = 4'd6,
		ACT_CLEAR         = 4'd7,
		ACT_STATUS        = 4'd8
	} action_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_MOD  = 1'b1
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/byte_ring_buffer_top.sv =====
// Timing: the done strobe comes in the cycle after a request, except for a skip or
// pointer advance that is taken, which returns once the modulo unit has stepped the pointer.
// Throughput: one request per cycle while not busy; busy holds until such a request returns.
// Byte memory is single-ported per side with a registered read.
// Reset (arst_n low) zeroes both pointers and closes any run; memory keeps its content.
// ----------------------------------------------------------------------------
// byte_ring_buffer_top
// Circular byte FIFO with one slot kept free, runs of writes and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_top #(
	parameter int CAPACITY = brb_pkg::CAPACITY_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [brb_pkg::ACT_W-1:0]      action,
	input  wire logic [brb_pkg::DATA_W-1:0]     data_byte,
	input  wire logic [brb_pkg::LEN_W-1:0]      length,
	output logic                                done,
	output logic                                accepted,
	output logic [brb_pkg::DATA_W-1:0]          read_data,
	output logic [brb_pkg::CNT_W-1:0]           stored_count,
	output logic [brb_pkg::CNT_W-1:0]           free_count,
	output logic [brb_pkg::CONTIG_W-1:0]        contiguous_write,
	output logic [brb_pkg::CNT_W-1:0]           read_position,
	output logic [brb_pkg::CNT_W-1:0]           write_position
);

	localparam int PW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > brb_pkg::CONTIG_W) ? CW : brb_pkg::CONTIG_W;
	localparam logic [PW-1:0] PTR_LAST = PW'(CAPACITY - 1);

	brb_pkg::state_t state_q, state_n;
	brb_pkg::kind_t  kind_q, kind_n;
	logic [PW-1:0]   rd_q, rd_n;
	logic [PW-1:0]   wr_q, wr_n;
	logic [brb_pkg::LEN_W-1:0] left_q, left_n;
	logic            sel_q, sel_n;
	logic            done_q, done_n;
	logic            acc_q, acc_n;
	logic            rdv_q, rdv_n;
	logic            wr_en, rd_en, red_go;
	logic [brb_pkg::DATA_W-1:0] mem [CAPACITY];
	logic [brb_pkg::DATA_W-1:0] rdata_s1;

	logic [EW-1:0]   stored_e, free_e, contig_e, len_e;
	logic [EW-1:0]   rd_pos_e, wr_pos_e;
	logic            run_idle;
	logic            red_done;
	logic [PW-1:0]   red_res;

	// occupancy seen from the current pointers
	always_comb begin
		if (wr_q >= rd_q) begin
			stored_e = EW'(wr_q) - EW'(rd_q);
			contig_e = EW'(CAPACITY) - EW'(wr_q);
		end else begin
			stored_e = EW'(CAPACITY) - (EW'(rd_q) - EW'(wr_q));
			contig_e = EW'(rd_q) - EW'(wr_q);
		end
		free_e = EW'(CAPACITY) - stored_e - 1'b1;
		len_e  = EW'(length);
	end

	assign run_idle = (kind_q == brb_pkg::KIND_NONE);

	brb_mod_unit #(
		.CAPACITY(CAPACITY)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (red_go),
		.ptr   (sel_n ? wr_q : rd_q),
		.len   (length),
		.done  (red_done),
		.result(red_res)
	);

	always_comb begin
		state_n = state_q;
		kind_n  = kind_q;
		rd_n    = rd_q;
		wr_n    = wr_q;
		left_n  = left_q;
		sel_n   = sel_q;
		done_n  = 1'b0;
		acc_n   = 1'b0;
		rdv_n   = 1'b0;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		red_go  = 1'b0;
		unique case (state_q)
			brb_pkg::ST_IDLE: begin
				if (start) begin
					done_n = 1'b1;
					unique case (brb_pkg::action_t'(action))
						brb_pkg::ACT_BEGIN_WRITE: begin
							if (run_idle && length != '0 && len_e <= free_e) begin
								kind_n = brb_pkg::KIND_WRITE;
								left_n = length;
								acc_n  = 1'b1;
							end
						end
						brb_pkg::ACT_WRITE_BYTE: begin
							if (kind_q == brb_pkg::KIND_WRITE && left_q != '0) begin
								wr_en  = 1'b1;
								wr_n   = (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
								left_n = left_q - 1'b1;
								if (left_q == brb_pkg::LEN_W'(1)) begin
									kind_n = brb_pkg::KIND_NONE;
								end
								acc_n = 1'b1;
							end
						end
						brb_pkg::ACT_BEGIN_READ: begin
							if (run_idle && length != '0 && len_e <= stored_e) begin
								kind_n = brb_pkg::KIND_READ;
								left_n = length;
								acc_n  = 1'b1;
							end
						end
						brb_pkg::ACT_READ_BYTE: begin
							if (kind_q == brb_pkg::KIND_READ && left_q != '0) begin
								rd_en  = 1'b1;
								rdv_n  = 1'b1;
								rd_n   = (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
								left_n = left_q - 1'b1;
								if (left_q == brb_pkg::LEN_W'(1)) begin
									kind_n = brb_pkg::KIND_NONE;
								end
								acc_n = 1'b1;
							end
						end
						brb_pkg::ACT_SKIP: begin
							if (run_idle && stored_e >= len_e) begin
								red_go = 1'b1;
								sel_n  = 1'b0;
							end
						end
						brb_pkg::ACT_ADVANCE_WRITE: begin
							if (run_idle) begin
								red_go = 1'b1;
								sel_n  = 1'b1;
							end
						end
						brb_pkg::ACT_ADVANCE_READ: begin
							if (run_idle) begin
								red_go = 1'b1;
								sel_n  = 1'b0;
							end
						end
						brb_pkg::ACT_CLEAR: begin
							rd_n   = '0;
							wr_n   = '0;
							left_n = '0;
							kind_n = brb_pkg::KIND_NONE;
							acc_n  = 1'b1;
						end
						brb_pkg::ACT_STATUS: begin
							acc_n = 1'b1;
						end
						default: begin
							acc_n = 1'b0;
						end
					endcase
					// hold the strobe until the modulo unit returns
					if (red_go) begin
						done_n  = 1'b0;
						state_n = brb_pkg::ST_MOD;
					end
				end
			end
			brb_pkg::ST_MOD: begin
				if (red_done) begin
					if (sel_q) begin
						wr_n = red_res;
					end else begin
						rd_n = red_res;
					end
					done_n  = 1'b1;
					acc_n   = 1'b1;
					state_n = brb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = brb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brb_pkg::ST_IDLE;
			kind_q  <= brb_pkg::KIND_NONE;
			rd_q    <= '0;
			wr_q    <= '0;
			left_q  <= '0;
			sel_q   <= 1'b0;
			done_q  <= 1'b0;
			acc_q   <= 1'b0;
			rdv_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			kind_q  <= kind_n;
			rd_q    <= rd_n;
			wr_q    <= wr_n;
			left_q  <= left_n;
			sel_q   <= sel_n;
			done_q  <= done_n;
			acc_q   <= acc_n;
			rdv_q   <= rdv_n;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_q] <= data_byte;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_q];
		end
	end

	assign rd_pos_e = EW'(rd_q);
	assign wr_pos_e = EW'(wr_q);

	assign busy             = (state_q == brb_pkg::ST_MOD);
	assign done             = done_q;
	assign accepted         = acc_q;
	assign read_data        = rdv_q ? rdata_s1 : '0;
	assign stored_count     = stored_e[brb_pkg::CNT_W-1:0];
	assign free_count       = free_e[brb_pkg::CNT_W-1:0];
	assign contiguous_write = contig_e[brb_pkg::CONTIG_W-1:0];
	assign read_position    = rd_pos_e[brb_pkg::CNT_W-1:0];
	assign write_position   = wr_pos_e[brb_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/brb_mod_unit.sv =====
// ----------------------------------------------------------------------------
// brb_mod_unit
// Pointer step (ptr + len) mod CAPACITY: reciprocal multiply, then one wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_mod_unit #(
	parameter int CAPACITY = brb_pkg::CAPACITY_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire logic [$clog2(CAPACITY)-1:0] ptr,
	input  wire logic [brb_pkg::LEN_W-1:0]   len,
	output logic                             done,
	output logic [$clog2(CAPACITY)-1:0]      result
);

	localparam int PW  = $clog2(CAPACITY);
	localparam int LW  = brb_pkg::LEN_W;
	localparam int MW  = LW + 2;
	localparam int PRW = LW + MW;
	localparam int QW  = LW + PW + 1;
	localparam int SW  = ((PW > LW) ? PW : LW) + 1;
	localparam int SH  = LW + PW;
	// ceil(2^SH / CAPACITY) yields the exact quotient for every LW-bit length
	localparam longint RECIP_L =
		((longint'(1) << SH) + longint'(CAPACITY) - 1) / longint'(CAPACITY);
	localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
	localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
	localparam logic [QW-1:0] CAP_Q = QW'(CAPACITY);

	logic [PRW-1:0] prod_w;
	logic [QW-1:0]  qc_w;
	logic [SW-1:0]  sum_w;
	logic [SW-1:0]  wrap_w;
	logic [LW-1:0]  quo_s1;
	logic [LW-1:0]  len_s1;
	logic [LW-1:0]  lmod_s2;
	logic [PW-1:0]  ptr_s1;
	logic [PW-1:0]  ptr_s2;
	logic [PW-1:0]  result_q;
	logic           vld_s1;
	logic           vld_s2;
	logic           done_q;

	always_comb begin
		prod_w = PRW'(len) * PRW'(RECIP);
		qc_w   = QW'(quo_s1) * CAP_Q;
		// ptr is below CAPACITY and so is the reduced length: one wrap is enough
		sum_w  = SW'(ptr_s2) + SW'(lmod_s2);
		wrap_w = (sum_w >= CAP_S) ? sum_w - CAP_S : sum_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= load;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_s1 <= LW'(prod_w >> SH);
			len_s1 <= len;
			ptr_s1 <= ptr;
		end
		if (vld_s1) begin
			lmod_s2 <= len_s1 - qc_w[LW-1:0];
			ptr_s2  <= ptr_s1;
		end
		if (vld_s2) begin
			result_q <= wrap_w[PW-1:0];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== rtl/brb_checker.sv =====
// ----------------------------------------------------------------------------
// brb_checker
// Port-level assertions for the byte ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module brb_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic                           busy,
	input  wire logic [brb_pkg::ACT_W-1:0]      action,
	input  wire logic [brb_pkg::DATA_W-1:0]     data_byte,
	input  wire logic [brb_pkg::LEN_W-1:0]      length,
	input  wire logic                           done,
	input  wire logic                           accepted,
	input  wire logic [brb_pkg::DATA_W-1:0]     read_data,
	input  wire logic [brb_pkg::CNT_W-1:0]      stored_count,
	input  wire logic [brb_pkg::CNT_W-1:0]      free_count,
	input  wire logic [brb_pkg::CONTIG_W-1:0]   contiguous_write,
	input  wire logic [brb_pkg::CNT_W-1:0]      read_position,
	input  wire logic [brb_pkg::CNT_W-1:0]      write_position
);

	`BRB_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !done && !busy,
		"strobe or busy in reset")
	`BRB_ASSERT(a_done_not_busy, done |-> !busy, "result strobe while busy")
	`BRB_ASSERT(a_status_answers,
		start && !busy && action == brb_pkg::ACT_STATUS |=> done && accepted,
		"status request not answered next cycle")
	`BRB_ASSERT(a_clear_empties,
		start && !busy && action == brb_pkg::ACT_CLEAR |=>
		done && read_position == '0 && write_position == '0 && stored_count == '0,
		"clear left data behind")
	`BRB_ASSERT(a_read_data_quiet, !done |-> read_data == '0 && data_byte == data_byte,
		"read data outside a result")

endmodule

bind byte_ring_buffer_top brb_checker u_brb_checker (.*);

`default_nettype wire

// ===== bench/byte_ring_buffer_top_tb.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer_top_tb
// Drives write runs, read runs, skips, pointer advances, clears and status
// requests into the ring buffer. Every request that the block takes is run
// through a local copy of the buffer. The status that comes back is compared
// field by field against that copy.
// ----------------------------------------------------------------------------
module byte_ring_buffer_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import brb_pkg::*;

	localparam int DEPTH        = CAPACITY_DEF;
	localparam int RANDOM_CNT   = 1850;
	localparam int DRAIN_EVERY  = 400;
	localparam int CALM_FIRST   = 700;
	localparam int CALM_LAST    = 1100;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 16;
	localparam int GEN_VIEW     = 0;
	localparam int CHK_VIEW     = 1;

	localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 4'd9;
	localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 4'd15;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0]  len;
		logic              drain;
	} ring_req_t;

	typedef struct packed {
		logic                accepted;
		logic [DATA_W-1:0]   rdata;
		logic [CNT_W-1:0]    stored;
		logic [CNT_W-1:0]    room;
		logic [CONTIG_W-1:0] contig;
		logic [CNT_W-1:0]    rpos;
		logic [CNT_W-1:0]    wpos;
	} ring_status_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b1;
	logic                start = 1'b0;
	logic [ACT_W-1:0]    action = ACT_STATUS;
	logic [DATA_W-1:0]   data_byte = '0;
	logic [LEN_W-1:0]    length = '0;
	logic                busy;
	logic                done;
	logic                accepted;
	logic [DATA_W-1:0]   read_data;
	logic [CNT_W-1:0]    stored_count;
	logic [CNT_W-1:0]    free_count;
	logic [CONTIG_W-1:0] contiguous_write;
	logic [CNT_W-1:0]    read_position;
	logic [CNT_W-1:0]    write_position;

	// Two copies of the buffer state: one steers stimulus generation, the
	// other follows the requests as the block takes them.
	logic [DATA_W-1:0] ring_mem [2][DEPTH];
	bit                written [DEPTH];
	int                rd_ix [2] = '{0, 0};
	int                wr_ix [2] = '{0, 0};
	int                run_left [2] = '{0, 0};
	kind_t             run_kind [2] = '{KIND_NONE, KIND_NONE};

	ring_req_t    req_q[$];
	ring_status_t status_q[$];
	int           sent_cnt = 0;
	int           fail_cnt = 0;
	int           quiet_cycles = 0;

	byte_ring_buffer_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.action           (action),
		.data_byte        (data_byte),
		.length           (length),
		.done             (done),
		.accepted         (accepted),
		.read_data        (read_data),
		.stored_count     (stored_count),
		.free_count       (free_count),
		.contiguous_write (contiguous_write),
		.read_position    (read_position),
		.write_position   (write_position)
	);

	always #1 clk = ~clk;

	function automatic int held_bytes(int v);
		if (wr_ix[v] >= rd_ix[v])
			return wr_ix[v] - rd_ix[v];
		return DEPTH - (rd_ix[v] - wr_ix[v]);
	endfunction

	function automatic void close_byte(int v);
		run_left[v]--;
		if (run_left[v] == 0)
			run_kind[v] = KIND_NONE;
	endfunction

	function automatic ring_status_t ring_apply(int v, ring_req_t r);
		ring_status_t s;
		bit           idle;
		int           held;
		s = '0;
		idle = (run_kind[v] == KIND_NONE);
		held = held_bytes(v);
		case (r.act)
			ACT_BEGIN_WRITE: begin
				if (idle && r.len != 0 && r.len <= DEPTH - held - 1) begin
					run_kind[v] = KIND_WRITE;
					run_left[v] = r.len;
					s.accepted = 1'b1;
				end
			end
			ACT_WRITE_BYTE: begin
				if (run_kind[v] == KIND_WRITE && run_left[v] != 0) begin
					ring_mem[v][wr_ix[v]] = r.data;
					written[wr_ix[v]] = 1'b1;
					wr_ix[v] = (wr_ix[v] + 1) % DEPTH;
					close_byte(v);
					s.accepted = 1'b1;
				end
			end
			ACT_BEGIN_READ: begin
				if (idle && r.len != 0 && r.len <= held) begin
					run_kind[v] = KIND_READ;
					run_left[v] = r.len;
					s.accepted = 1'b1;
				end
			end
			ACT_READ_BYTE: begin
				if (run_kind[v] == KIND_READ && run_left[v] != 0) begin
					s.rdata = ring_mem[v][rd_ix[v]];
					rd_ix[v] = (rd_ix[v] + 1) % DEPTH;
					close_byte(v);
					s.accepted = 1'b1;
				end
			end
			ACT_SKIP: begin
				if (idle && held >= r.len) begin
					rd_ix[v] = (rd_ix[v] + r.len) % DEPTH;
					s.accepted = 1'b1;
				end
			end
			ACT_ADVANCE_WRITE: begin
				if (idle) begin
					wr_ix[v] = (wr_ix[v] + r.len) % DEPTH;
					s.accepted = 1'b1;
				end
			end
			ACT_ADVANCE_READ: begin
				if (idle) begin
					rd_ix[v] = (rd_ix[v] + r.len) % DEPTH;
					s.accepted = 1'b1;
				end
			end
			ACT_CLEAR: begin
				rd_ix[v] = 0;
				wr_ix[v] = 0;
				run_left[v] = 0;
				run_kind[v] = KIND_NONE;
				s.accepted = 1'b1;
			end
			ACT_STATUS: s.accepted = 1'b1;
			default: ;
		endcase
		s.stored = CNT_W'(held_bytes(v));
		s.room = CNT_W'(DEPTH - held_bytes(v) - 1);
		s.contig = CONTIG_W'((wr_ix[v] >= rd_ix[v]) ? DEPTH - wr_ix[v] : rd_ix[v] - wr_ix[v]);
		s.rpos = CNT_W'(rd_ix[v]);
		s.wpos = CNT_W'(wr_ix[v]);
		return s;
	endfunction

	function automatic void push_req(logic [ACT_W-1:0] act, logic [DATA_W-1:0] data, int len);
		ring_req_t r;
		r.act = act;
		r.data = data;
		r.len = LEN_W'(len);
		r.drain = (req_q.size() % DRAIN_EVERY == DRAIN_EVERY - 1);
		void'(ring_apply(GEN_VIEW, r));
		req_q.push_back(r);
	endfunction

	// Stored bytes from the read pointer on that were written at some point.
	function automatic int readable_run();
		int n;
		int held;
		n = 0;
		held = held_bytes(GEN_VIEW);
		while (n < held && written[(rd_ix[GEN_VIEW] + n) % DEPTH])
			n++;
		return n;
	endfunction

	// Requests that the block refuses, that only move pointers, or that only ask for status.
	task automatic push_stray(kind_t open_kind);
		int pick;
		int held;
		int room;
		int len;
		pick = $urandom_range(9);
		held = held_bytes(GEN_VIEW);
		room = DEPTH - held - 1;
		case (pick)
			1: begin
				if (open_kind != KIND_NONE || $urandom_range(3) == 0)
					len = $urandom_range(0, 4095);
				else
					len = $urandom_range(0, held);
				push_req(ACT_SKIP, 8'($urandom), len);
			end
			2, 3: begin
				len = ($urandom_range(7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 32);
				push_req((pick == 2) ? ACT_ADVANCE_WRITE : ACT_ADVANCE_READ, 8'($urandom), len);
			end
			4: begin
				// zero or oversized begin; any length while a run is open
				if (open_kind != KIND_NONE)
					len = $urandom_range(0, 4095);
				else if (room < 4095 && $urandom_range(1) == 0)
					len = $urandom_range(room + 1, 4095);
				else
					len = 0;
				push_req(ACT_BEGIN_WRITE, 8'($urandom), len);
			end
			5: begin
				if (open_kind != KIND_NONE)
					len = $urandom_range(0, 4095);
				else if (held < 4095 && $urandom_range(1) == 0)
					len = $urandom_range(held + 1, 4095);
				else
					len = 0;
				push_req(ACT_BEGIN_READ, 8'($urandom), len);
			end
			6, 9: begin
				// byte request of the wrong kind, or with no run at all
				if (open_kind == KIND_WRITE || (open_kind == KIND_NONE && $urandom_range(1) == 0))
					push_req(ACT_READ_BYTE, 8'($urandom), $urandom_range(0, 4095));
				else
					push_req(ACT_WRITE_BYTE, 8'($urandom), $urandom_range(0, 4095));
			end
			7: push_req(4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), 8'($urandom),
				$urandom_range(0, 4095));
			8: begin
				if (open_kind == KIND_NONE)
					push_req(ACT_CLEAR, 8'($urandom), $urandom_range(0, 4095));
				else
					push_req(ACT_STATUS, 8'($urandom), $urandom_range(0, 4095));
			end
			default: push_req(ACT_STATUS, 8'($urandom), $urandom_range(0, 4095));
		endcase
	endtask

	task automatic write_run();
		int room;
		int cap;
		int len;
		int i;
		room = DEPTH - held_bytes(GEN_VIEW) - 1;
		if (room == 0) begin
			push_req(ACT_SKIP, 8'($urandom), $urandom_range(1, 64));
			return;
		end
		cap = ($urandom_range(19) == 0) ? 200 : 16;
		if (cap > room)
			cap = room;
		len = $urandom_range(1, cap);
		push_req(ACT_BEGIN_WRITE, 8'($urandom), len);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(29) == 0)
				push_stray(KIND_WRITE);
			if ($urandom_range(299) == 0) begin
				// drop the run before its last byte
				push_req(ACT_CLEAR, 8'($urandom), $urandom_range(0, 4095));
				return;
			end
			push_req(ACT_WRITE_BYTE, 8'($urandom), $urandom_range(0, 4095));
		end
	endtask

	task automatic read_run();
		int avail;
		int cap;
		int len;
		int i;
		// never open a read over entries that were never written
		avail = readable_run();
		if (avail == 0) begin
			write_run();
			return;
		end
		cap = ($urandom_range(19) == 0) ? 200 : 16;
		if (cap > avail)
			cap = avail;
		len = $urandom_range(1, cap);
		push_req(ACT_BEGIN_READ, 8'($urandom), len);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(29) == 0)
				push_stray(KIND_READ);
			if ($urandom_range(299) == 0) begin
				push_req(ACT_CLEAR, 8'($urandom), $urandom_range(0, 4095));
				return;
			end
			push_req(ACT_READ_BYTE, 8'($urandom), $urandom_range(0, 4095));
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	// Request driver: hold an offered request until the block takes it.
	always @(posedge clk) begin
		bit idle_now;
		bit drained;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				status_q.push_back(ring_apply(CHK_VIEW, req_q[0]));
				void'(req_q.pop_front());
				sent_cnt++;
			end
			idle_now = (sent_cnt < CALM_FIRST || sent_cnt >= CALM_LAST) && $urandom_range(99) < 15;
			drained = (status_q.size() == 0) && !done;
			if (!start || !busy) begin
				if (req_q.size() != 0 && !idle_now && (!req_q[0].drain || drained)) begin
					start <= 1'b1;
					action <= req_q[0].act;
					data_byte <= req_q[0].data;
					length <= req_q[0].len;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Status monitor
	always @(posedge clk) begin
		ring_status_t want;
		if (arst_n && done) begin
			if (status_q.size() == 0) begin
				$error("status returned with no request outstanding");
				fail_cnt++;
			end else begin
				want = status_q.pop_front();
				check_field("accepted", want.accepted, accepted);
				check_field("read_data", want.rdata, read_data);
				check_field("stored_count", want.stored, stored_count);
				check_field("free_count", want.room, free_count);
				check_field("contiguous_write", want.contig, contiguous_write);
				check_field("read_position", want.rpos, read_position);
				check_field("write_position", want.wpos, write_position);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$error("no request taken and no status returned for %0d cycles", QUIET_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int pick;

		// drop reset with a real edge so the flops clear before the first clock
		arst_n <= 1'b0;

		// directed: refusals, run open and close, full and empty, wrap, clear
		push_req(ACT_STATUS, 8'h00, 0);
		push_req(ACT_BEGIN_READ, 8'h00, 1);
		push_req(ACT_READ_BYTE, 8'h00, 0);
		push_req(ACT_WRITE_BYTE, 8'h5A, 0);
		push_req(ACT_BEGIN_WRITE, 8'h00, 0);
		push_req(ACT_BEGIN_WRITE, 8'h00, 3);
		push_req(ACT_BEGIN_READ, 8'h00, 1);
		push_req(ACT_SKIP, 8'h00, 0);
		push_req(ACT_READ_BYTE, 8'h00, 0);
		push_req(ACT_WRITE_BYTE, 8'h00, 0);
		push_req(ACT_WRITE_BYTE, 8'hFF, 4095);
		push_req(ACT_WRITE_BYTE, 8'hA5, 0);
		push_req(ACT_WRITE_BYTE, 8'h11, 0);
		push_req(ACT_BEGIN_READ, 8'h00, 4);
		push_req(ACT_BEGIN_READ, 8'h00, 2);
		push_req(ACT_ADVANCE_READ, 8'h00, 1);
		push_req(ACT_READ_BYTE, 8'h00, 0);
		push_req(ACT_READ_BYTE, 8'h00, 0);
		push_req(ACT_SKIP, 8'h00, 2);
		push_req(ACT_SKIP, 8'h00, 1);
		push_req(ACT_ADVANCE_WRITE, 8'h00, 4095);
		push_req(ACT_BEGIN_WRITE, 8'h00, 1);
		push_req(ACT_ADVANCE_READ, 8'h00, 4095);
		push_req(ACT_UNUSED_LO, 8'hFF, 4095);
		push_req(ACT_UNUSED_HI, 8'h00, 0);
		push_req(ACT_CLEAR, 8'h00, 0);
		push_req(ACT_BEGIN_WRITE, 8'h00, 4095);
		push_req(ACT_CLEAR, 8'h00, 0);

		while (req_q.size() < 28 + RANDOM_CNT) begin
			pick = $urandom_range(99);
			if (pick < 42)
				write_run();
			else if (pick < 80)
				read_run();
			else
				push_stray(KIND_NONE);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (req_q.size() != 0 || start || status_q.size() != 0 || done);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (status_q.size() != 0) begin
			$error("%0d status results never returned", status_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
